// ===== rtl/yay0_pkg.sv =====
package yay0_pkg;

  // History window and result packing.
  localparam int WINDOW_DEPTH     = 4096;
  localparam int ADDR_W           = $clog2(WINDOW_DEPTH);
  localparam int BYTES_PER_RESULT = 8;
  localparam int LANE_W           = $clog2(BYTES_PER_RESULT);

  // Fixed field widths of the stream format.
  localparam int COUNT_W   = 4;   // byte_count field
  localparam int DIST_W    = 12;  // distance field of a link halfword
  localparam int LEN_SHIFT = 12;  // position of the length nibble in a link
  localparam int RUN_W     = 9;   // holds the longest run, 255 + 18
  localparam int BW_W      = 25;  // output length plus one run never exceeds this
  localparam int OLEN_W    = 24;
  localparam int LEFT_W    = 6;

  localparam logic [LEFT_W-1:0] MASK_BITS  = 6'd32;
  localparam logic [RUN_W-1:0]  SHORT_BIAS = 9'd2;
  localparam logic [RUN_W-1:0]  LONG_BIAS  = 9'd18;

  // Item kinds, both for the operation field and for next_need.
  localparam logic [1:0] NEED_MASK = 2'd0;
  localparam logic [1:0] NEED_LINK = 2'd1;
  localparam logic [1:0] NEED_RAW  = 2'd2;

  // Per-input status carried by every result beat of that input.
  typedef struct packed {
    logic       kind_error;
    logic       finished;
    logic [1:0] next_need;
  } meta_t;

endpackage

// ===== rtl/yay0_decompressor_core.sv =====
// Timing: a mask word, a link with a zero length nibble, a literal or a rejected item is taken
// while the sequencer idles; its single result beat is valid in the output register the cycle after.
// Throughput: such items go at one per cycle while the output is drained; a copy holds the input
// until all its bytes are moved, since each byte is a history RAM read followed by a write.
// Reset: rst (synchronous) clears the mask, counters, flags and output length; the history
// RAM is not cleared and needs no clearing pass, so the block is ready right after reset.
module yay0_decompressor_core (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // item_value[31:0]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // data_bytes[63:0], byte_count[67:64], zero pad[71:68]
  output logic        m_tlast,   // last_of_run
  output logic [3:0]  m_tuser,   // next_need[1:0], finished[2], kind_error[3]
  // Configuration: output_length.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [23:0] cfg_data
);

  // The sequencer idles while it takes items; a back-reference alternates between a
  // read of the history byte and the write of that byte at the current position, so an
  // overlapping copy always sees the byte written one step before.
  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t                         state;
  state_t                         state_next;

  // Decoder state.
  logic [yay0_pkg::OLEN_W-1:0]    out_len;
  logic [31:0]                    mask;
  logic [yay0_pkg::LEFT_W-1:0]    mask_left;
  logic [yay0_pkg::DIST_W-1:0]    link_dist;
  logic [1:0]                     expected;
  logic [yay0_pkg::BW_W-1:0]      bytes_written;
  logic                           done;
  logic [yay0_pkg::ADDR_W-1:0]    wpos;
  logic [yay0_pkg::RUN_W-1:0]     run_left;
  yay0_pkg::meta_t                meta_q;

  // Decode of the item on the input port.
  logic                           accept;
  logic                           eff_done;
  logic                           is_err;
  logic                           take;
  logic                           do_literal;
  logic                           do_copy;
  logic [yay0_pkg::RUN_W-1:0]     copy_len;
  logic [yay0_pkg::RUN_W-1:0]     produced;
  logic [yay0_pkg::BW_W:0]        bw_after;
  logic                           fin;
  logic [31:0]                    mask_next;
  logic [yay0_pkg::LEFT_W-1:0]    left_next;
  logic [1:0]                     expected_next;
  logic [31:0]                    mask_adv;
  logic [yay0_pkg::LEFT_W-1:0]    left_adv;
  logic [1:0]                     expected_adv;
  logic [3:0]                     nibble;
  yay0_pkg::meta_t                meta_now;

  // History RAM and packer hookup.
  logic                           ram_we;
  logic [7:0]                     ram_wdata;
  logic                           ram_re;
  logic [yay0_pkg::ADDR_W-1:0]    ram_raddr;
  logic [7:0]                     ram_rdata;
  logic                           pk_push;
  logic [7:0]                     pk_byte;
  logic                           pk_close;
  logic                           pk_ready;
  yay0_pkg::meta_t                pk_meta;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && pk_ready;
  assign accept    = s_tvalid && s_tready;

  // What the mask looks like after one of its bits has been used up.
  always_comb begin
    mask_adv  = mask << 1;
    left_adv  = (mask_left != '0) ? mask_left - 1'b1 : mask_left;
    if (left_adv == '0) begin
      expected_adv = yay0_pkg::NEED_MASK;
    end else begin
      expected_adv = mask_adv[31] ? yay0_pkg::NEED_RAW : yay0_pkg::NEED_LINK;
    end
  end

  // Item decode. Everything the result beats report (next kind, finished) is known as
  // soon as the item arrives, because a run's length is fixed by the item itself.
  always_comb begin
    eff_done      = done || (bytes_written >= yay0_pkg::BW_W'(out_len));
    is_err        = !eff_done && (s_tuser != expected);
    take          = !eff_done && !is_err;
    nibble        = s_tdata[15:12];
    do_literal    = 1'b0;
    do_copy       = 1'b0;
    copy_len      = '0;
    mask_next     = mask;
    left_next     = mask_left;
    expected_next = expected;
    if (take) begin
      unique case (s_tuser)
        yay0_pkg::NEED_MASK: begin
          mask_next     = s_tdata;
          left_next     = yay0_pkg::MASK_BITS;
          expected_next = s_tdata[31] ? yay0_pkg::NEED_RAW : yay0_pkg::NEED_LINK;
        end
        yay0_pkg::NEED_LINK: begin
          if (nibble != 4'd0) begin
            do_copy       = 1'b1;
            copy_len      = yay0_pkg::RUN_W'(nibble) + yay0_pkg::SHORT_BIAS;
            mask_next     = mask_adv;
            left_next     = left_adv;
            expected_next = expected_adv;
          end else begin
            // A zero nibble means the run length follows as a raw byte.
            expected_next = yay0_pkg::NEED_RAW;
          end
        end
        yay0_pkg::NEED_RAW: begin
          if (mask[31]) begin
            do_literal = 1'b1;
          end else begin
            do_copy  = 1'b1;
            copy_len = yay0_pkg::RUN_W'(s_tdata[7:0]) + yay0_pkg::LONG_BIAS;
          end
          mask_next     = mask_adv;
          left_next     = left_adv;
          expected_next = expected_adv;
        end
        default: begin
          // An operation code of 3 never matches the expected kind.
        end
      endcase
    end
    produced = do_copy ? copy_len : yay0_pkg::RUN_W'(do_literal);
    bw_after = (yay0_pkg::BW_W + 1)'(bytes_written) + (yay0_pkg::BW_W + 1)'(produced);
    fin      = bw_after >= (yay0_pkg::BW_W + 1)'(out_len);
    meta_now.kind_error = is_err;
    meta_now.finished   = eff_done || fin;
    meta_now.next_need  = expected_next;
  end

  // Sequencer, RAM access and packer control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_wdata  = s_tdata[7:0];
    ram_re     = 1'b0;
    ram_raddr  = wpos - yay0_pkg::ADDR_W'(link_dist) - 1'b1;
    pk_push    = 1'b0;
    pk_byte    = s_tdata[7:0];
    pk_close   = 1'b0;
    pk_meta    = meta_q;
    unique case (state)
      S_IDLE: begin
        pk_meta = meta_now;
        if (accept) begin
          if (do_copy) begin
            state_next = S_READ;
          end else begin
            // Literals and items without output finish in the accept cycle.
            ram_we   = do_literal;
            pk_push  = do_literal;
            pk_close = 1'b1;
          end
        end
      end
      S_READ: begin
        ram_re     = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ram_wdata = ram_rdata;
        pk_byte   = ram_rdata;
        if (pk_ready) begin
          ram_we   = 1'b1;
          pk_push  = 1'b1;
          pk_close = (run_left == yay0_pkg::RUN_W'(1));
          state_next = pk_close ? S_IDLE : S_READ;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta_q <= meta_now;
      if (take && s_tuser == yay0_pkg::NEED_LINK) begin
        link_dist <= s_tdata[yay0_pkg::DIST_W-1:0];
      end
    end
    if (rst) begin
      state         <= S_IDLE;
      out_len       <= '0;
      mask          <= '0;
      mask_left     <= '0;
      expected      <= yay0_pkg::NEED_MASK;
      bytes_written <= '0;
      done          <= 1'b0;
      wpos          <= '0;
      run_left      <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        out_len <= cfg_data;
      end
      if (accept) begin
        mask      <= mask_next;
        mask_left <= left_next;
        expected  <= expected_next;
        done      <= eff_done || fin;
        run_left  <= copy_len;
      end else if (state == S_WRITE && pk_ready) begin
        run_left <= run_left - 1'b1;
      end
      if (ram_we) begin
        wpos          <= wpos + 1'b1;
        bytes_written <= bytes_written + 1'b1;
      end
    end
  end

  yay0_ram #(
    .WIDTH (8),
    .DEPTH (yay0_pkg::WINDOW_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  yay0_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .push      (pk_push),
    .push_byte (pk_byte),
    .close     (pk_close),
    .meta      (pk_meta),
    .ready     (pk_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // The packer may only be fed while its output slot can take a beat.
  a_pack_fed_when_ready: assert property (@(posedge clk) disable iff (rst)
    (pk_push || pk_close) |-> pk_ready)
    else $error("packer fed while its output slot is blocked");

  // Every history read is followed by its write phase.
  a_read_then_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_WRITE))
    else $error("history read not followed by write phase");

  // A copy in progress always has bytes left to move.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (run_left != '0))
    else $error("copy active with no bytes left");

  // The end of the stream is sticky until reset.
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done |=> done)
    else $error("finished flag dropped");

endmodule

// ===== rtl/yay0_ram.sv =====
module yay0_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/yay0_pack.sv =====
module yay0_pack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [7:0]            push_byte,
  input  logic                  close,
  input  yay0_pkg::meta_t       meta,
  output logic                  ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [71:0]           m_tdata,
  output logic                  m_tlast,
  output logic [3:0]            m_tuser
);

  logic [7:0]                     lane [yay0_pkg::BYTES_PER_RESULT];
  logic [yay0_pkg::LANE_W-1:0]    buf_cnt;
  logic [yay0_pkg::COUNT_W-1:0]   cnt_new;
  logic                           emit;
  logic [63:0]                    data_next;

  logic                           out_valid;
  logic [63:0]                    out_data;
  logic [yay0_pkg::COUNT_W-1:0]   out_cnt;
  logic                           out_last;
  yay0_pkg::meta_t                out_meta;

  assign ready = !out_valid || m_tready;

  always_comb begin
    cnt_new = yay0_pkg::COUNT_W'(buf_cnt) + yay0_pkg::COUNT_W'(push);
    emit    = close ||
              (push && buf_cnt == yay0_pkg::LANE_W'(yay0_pkg::BYTES_PER_RESULT - 1));
    data_next = '0;
    for (int i = 0; i < yay0_pkg::BYTES_PER_RESULT; i++) begin
      if (yay0_pkg::COUNT_W'(i) < cnt_new) begin
        if (push && yay0_pkg::LANE_W'(i) == buf_cnt) begin
          data_next[i*8 +: 8] = push_byte;
        end else begin
          data_next[i*8 +: 8] = lane[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      lane[buf_cnt] <= push_byte;
    end
    if (emit) begin
      out_data <= data_next;
      out_cnt  <= cnt_new;
      out_last <= close;
      out_meta <= meta;
    end
    if (rst) begin
      buf_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        buf_cnt <= '0;
      end else if (push) begin
        buf_cnt <= buf_cnt + 1'b1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_cnt, out_data};
  assign m_tlast  = out_last;
  assign m_tuser  = out_meta;

endmodule
